>>> hw/rtl/gnq_pkg.sv
// gnq_pkg: shared widths, codes and limits of the uniform grid neighbor query unit
// no dependencies
package gnq_pkg;

  localparam int POS_W    = 16;
  localparam int EDGE_W   = 15;
  localparam int IDX_W    = 10;
  localparam int DIM_W    = 6;
  localparam int CFG_W    = 15;
  localparam int CFG_IX_W = 2;
  localparam int QUOT_W   = 16;
  localparam int OUT_CAP  = 64;
  localparam int CNT_W    = $clog2(OUT_CAP + 1);

  localparam int DEF_MAX_COLS   = 32;
  localparam int DEF_MAX_ROWS   = 32;
  localparam int DEF_BUCKET_CAP = 8;
  localparam int DEF_MAX_ITEMS  = 1024;
  localparam int DEF_MAX_SPAN   = 4;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DROP  = 2'd1,
    ST_TRUNC = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1,
    REG_EDGE = 2'd2,
    REG_WRAP = 2'd3
  } reg_ix_t;

  localparam logic [DIM_W-1:0]  RST_COLS = 6'd32;
  localparam logic [DIM_W-1:0]  RST_ROWS = 6'd32;
  localparam logic [EDGE_W-1:0] RST_EDGE = 15'd256;
  localparam logic              RST_WRAP = 1'b1;

endpackage

>>> hw/rtl/gnq_if.sv
// gnq_in_if / gnq_out_if: valid-ready request and result channels of the neighbor query unit
// depends on gnq_pkg
interface gnq_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [gnq_pkg::IDX_W-1:0]           item_index;
  logic signed [gnq_pkg::POS_W-1:0]    pos_x;
  logic signed [gnq_pkg::POS_W-1:0]    pos_y;
  logic [gnq_pkg::EDGE_W-1:0]          search_radius;
  modport source (output valid, action, item_index, pos_x, pos_y, search_radius,
                  input ready);
  modport sink   (input valid, action, item_index, pos_x, pos_y, search_radius,
                  output ready);
endinterface

interface gnq_out_if;
  logic                      valid;
  logic                      ready;
  logic [gnq_pkg::IDX_W-1:0] found_index;
  logic                      found_valid;
  logic                      last;
  logic [1:0]                status;
  modport source (output valid, found_index, found_valid, last, status, input ready);
  modport sink   (input valid, found_index, found_valid, last, status, output ready);
endinterface

>>> hw/rtl/uniform_grid_neighbor_query_unit.sv
// uniform grid neighbor query unit: sequencer, bucket fill and entry rams, shared divider
// one request at a time; inserts and queries go through the serial divider and the ram walk
// after reset a clearing pass empties all buckets
// depends on gnq_pkg, gnq_if, gnq_ram, gnq_div
module uniform_grid_neighbor_query_unit #(
  parameter int MAX_COLS   = gnq_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS   = gnq_pkg::DEF_MAX_ROWS,
  parameter int BUCKET_CAP = gnq_pkg::DEF_BUCKET_CAP,
  parameter int MAX_ITEMS  = gnq_pkg::DEF_MAX_ITEMS,
  parameter int MAX_SPAN   = gnq_pkg::DEF_MAX_SPAN
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gnq_pkg::CFG_IX_W-1:0]  cfg_index,
  input  logic [gnq_pkg::CFG_W-1:0]     cfg_data,
  gnq_in_if.sink                        in_chan,
  gnq_out_if.source                     out_chan
);
  localparam int NUM_CELLS = MAX_COLS * MAX_ROWS;
  localparam int NUM_ENT   = NUM_CELLS * BUCKET_CAP;
  localparam int CAW  = NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1;
  localparam int EAW  = NUM_ENT > 1 ? $clog2(NUM_ENT) : 1;
  localparam int FW   = $clog2(BUCKET_CAP + 1);
  localparam int GMAX = MAX_COLS > MAX_ROWS ? MAX_COLS : MAX_ROWS;
  localparam int RW   = $clog2(GMAX + MAX_SPAN + 1) + 1;
  localparam int NCW  = $clog2(GMAX + 1);
  localparam int SPW  = $clog2(MAX_SPAN + 1);
  localparam int DCW  = $clog2(2 * MAX_SPAN + 1);
  localparam int QW   = gnq_pkg::QUOT_W;
  localparam int IW   = gnq_pkg::IDX_W;

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DIVX  = 14'b00000000000100,
    S_DIVY  = 14'b00000000001000,
    S_DIVS  = 14'b00000000010000,
    S_WRAPC = 14'b00000000100000,
    S_WRAPR = 14'b00000001000000,
    S_CELL  = 14'b00000010000000,
    S_FRD   = 14'b00000100000000,
    S_FWAIT = 14'b00001000000000,
    S_ERD   = 14'b00010000000000,
    S_EWAIT = 14'b00100000000000,
    S_INS   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  state_t state_r;

  // configuration
  logic [gnq_pkg::DIM_W-1:0]  cols_cfg_r, rows_cfg_r;
  logic [gnq_pkg::EDGE_W-1:0] edge_cfg_r;
  logic                       wrap_r;
  logic [NCW-1:0]             cols_u, rows_u;
  logic [gnq_pkg::EDGE_W-1:0] edge_u;
  logic signed [RW-1:0]       cols_s, rows_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= gnq_pkg::RST_COLS;
      rows_cfg_r <= gnq_pkg::RST_ROWS;
      edge_cfg_r <= gnq_pkg::RST_EDGE;
      wrap_r     <= gnq_pkg::RST_WRAP;
    end else if (cfg_we) begin
      unique case (gnq_pkg::reg_ix_t'(cfg_index))
        gnq_pkg::REG_COLS: cols_cfg_r <= cfg_data[gnq_pkg::DIM_W-1:0];
        gnq_pkg::REG_ROWS: rows_cfg_r <= cfg_data[gnq_pkg::DIM_W-1:0];
        gnq_pkg::REG_EDGE: edge_cfg_r <= cfg_data;
        gnq_pkg::REG_WRAP: wrap_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_cfg_r == '0) cols_u = NCW'(1);
    else if (32'(cols_cfg_r) > 32'(MAX_COLS)) cols_u = NCW'(MAX_COLS);
    else cols_u = NCW'(cols_cfg_r);
    if (rows_cfg_r == '0) rows_u = NCW'(1);
    else if (32'(rows_cfg_r) > 32'(MAX_ROWS)) rows_u = NCW'(MAX_ROWS);
    else rows_u = NCW'(rows_cfg_r);
    edge_u = (edge_cfg_r == '0) ? gnq_pkg::EDGE_W'(1) : edge_cfg_r;
  end

  assign cols_s = RW'(cols_u);
  assign rows_s = RW'(rows_u);

  // latched request
  logic [1:0]                    act_r;
  logic [IW-1:0]                 item_r;
  logic signed [gnq_pkg::POS_W-1:0] py_r;
  logic [gnq_pkg::EDGE_W-1:0]    rad_r;

  // divider
  logic          div_start, div_done;
  logic [QW-1:0] div_a, div_q;

  gnq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (edge_u),
    .done     (div_done),
    .quotient (div_q)
  );

  logic accept;
  assign in_chan.ready = (state_r == S_IDLE);
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    if (state_r == S_IDLE) begin
      div_start = accept && (in_chan.action == gnq_pkg::ACT_INSERT ||
                             in_chan.action == gnq_pkg::ACT_QUERY);
      div_a     = in_chan.pos_x[gnq_pkg::POS_W-1] ? '0 : QW'(unsigned'(in_chan.pos_x));
    end else if (state_r == S_DIVX) begin
      div_start = div_done;
      div_a     = py_r[gnq_pkg::POS_W-1] ? '0 : QW'(unsigned'(py_r));
    end else if (state_r == S_DIVY) begin
      div_start = div_done && (act_r == gnq_pkg::ACT_QUERY);
      div_a     = QW'(rad_r) + QW'(edge_u) - QW'(1);
    end
  end

  // clamped coordinate from quotient
  logic [QW-1:0] lim_c, lim_r, col_q, row_q, spn_q;
  assign lim_c = QW'(cols_u) - QW'(1);
  assign lim_r = QW'(rows_u) - QW'(1);
  assign col_q = div_q > lim_c ? lim_c : div_q;
  assign row_q = div_q > lim_r ? lim_r : div_q;
  assign spn_q = div_q > QW'(MAX_SPAN) ? QW'(MAX_SPAN) : div_q;

  // walk state
  logic signed [RW-1:0] cc_r, c_raw_r, c_w_r, c0_raw_r, c0_w_r, r_raw_r, r_w_r;
  logic [SPW-1:0]       span_r;
  logic [DCW-1:0]       dc_r, dr_r;
  logic [CAW-1:0]       cell_r, clr_cnt_r;
  logic [FW-1:0]        fill_r, k_r;
  logic [gnq_pkg::CNT_W-1:0] n_r;
  logic [IW-1:0]        pend_r;

  logic [DCW-1:0]       span2;
  logic                 last_col, walk_done, in_range;
  logic signed [RW-1:0] c_inc, r_inc;
  logic signed [RW-1:0] span_s;

  assign span2     = DCW'({span_r, 1'b0});
  assign last_col  = dc_r == span2;
  assign walk_done = last_col && (dr_r == span2);
  assign c_inc     = (c_w_r + RW'(1) == cols_s) ? '0 : c_w_r + RW'(1);
  assign r_inc     = (r_w_r + RW'(1) == rows_s) ? '0 : r_w_r + RW'(1);
  assign in_range  = !c_raw_r[RW-1] && (c_raw_r < cols_s) &&
                     !r_raw_r[RW-1] && (r_raw_r < rows_s);
  assign span_s    = RW'(spn_q);

  // rams
  logic           f_we, f_re, e_we, e_re;
  logic [CAW-1:0] f_waddr;
  logic [FW-1:0]  f_wdata, f_rdata;
  logic [EAW-1:0] e_addr_w, e_addr_r;
  logic [IW-1:0]  e_rdata;
  logic           drop;
  logic           out_free;

  assign drop     = (fill_r >= FW'(BUCKET_CAP)) || (32'(item_r) >= 32'(MAX_ITEMS));
  assign out_free = !out_chan.valid || out_chan.ready;
  assign f_we     = (state_r == S_CLR) || (state_r == S_INS && out_free && !drop);
  assign f_waddr  = (state_r == S_CLR) ? clr_cnt_r : cell_r;
  assign f_wdata  = (state_r == S_CLR) ? '0 : fill_r + FW'(1);
  assign f_re     = (state_r == S_FRD);
  assign e_we     = (state_r == S_INS) && out_free && !drop;
  assign e_addr_w = EAW'(cell_r) * EAW'(BUCKET_CAP) + EAW'(fill_r);
  assign e_addr_r = EAW'(cell_r) * EAW'(BUCKET_CAP) + EAW'(k_r);
  assign e_re     = (state_r == S_ERD) && (k_r < fill_r);

  gnq_ram #(.WIDTH(FW), .DEPTH(NUM_CELLS)) u_fill (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(cell_r), .rdata(f_rdata)
  );

  gnq_ram #(.WIDTH(IW), .DEPTH(NUM_ENT)) u_ent (
    .clk(clk), .we(e_we), .waddr(e_addr_w), .wdata(item_r),
    .re(e_re), .raddr(e_addr_r), .rdata(e_rdata)
  );

  // output register
  logic                    out_v_r, out_fv_r, out_last_r;
  logic [IW-1:0]           out_idx_r;
  gnq_pkg::status_t        out_st_r;
  logic                    out_load;

  assign out_load = out_free && (state_r == S_INS || state_r == S_FIN ||
                                 (state_r == S_EWAIT && n_r != '0));

  assign out_chan.valid       = out_v_r;
  assign out_chan.found_index = out_idx_r;
  assign out_chan.found_valid = out_fv_r;
  assign out_chan.last        = out_last_r;
  assign out_chan.status      = out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (out_load) out_v_r <= 1'b1;
      else if (out_chan.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + CAW'(1);
          if (clr_cnt_r == CAW'(NUM_CELLS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          clr_cnt_r <= '0;
          if (accept) begin
            act_r  <= in_chan.action;
            item_r <= in_chan.item_index;
            py_r   <= in_chan.pos_y;
            rad_r  <= in_chan.search_radius;
            if (in_chan.action == gnq_pkg::ACT_CLEAR) state_r <= S_CLR;
            else if (div_start) state_r <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            cc_r    <= RW'(col_q);
            c_raw_r <= RW'(col_q);
            c_w_r   <= RW'(col_q);
            state_r <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            r_raw_r <= RW'(row_q);
            r_w_r   <= RW'(row_q);
            state_r <= (act_r == gnq_pkg::ACT_QUERY) ? S_DIVS : S_CELL;
          end
        end
        S_DIVS: begin
          if (div_done) begin
            span_r   <= SPW'(spn_q);
            c_raw_r  <= cc_r - span_s;
            c_w_r    <= cc_r - span_s;
            c0_raw_r <= cc_r - span_s;
            r_raw_r  <= r_raw_r - span_s;
            r_w_r    <= r_raw_r - span_s;
            dc_r     <= '0;
            dr_r     <= '0;
            n_r      <= '0;
            state_r  <= S_WRAPC;
          end
        end
        S_WRAPC: begin
          if (c_w_r[RW-1]) c_w_r <= c_w_r + cols_s;
          else begin
            c0_w_r  <= c_w_r;
            state_r <= S_WRAPR;
          end
        end
        S_WRAPR: begin
          if (r_w_r[RW-1]) r_w_r <= r_w_r + rows_s;
          else state_r <= S_CELL;
        end
        S_CELL: begin
          cell_r <= CAW'(unsigned'(r_w_r)) * CAW'(cols_u) + CAW'(unsigned'(c_w_r));
          if (act_r == gnq_pkg::ACT_QUERY && !wrap_r && !in_range) begin
            if (walk_done) state_r <= S_FIN;
            else if (last_col) begin
              dc_r <= '0; c_raw_r <= c0_raw_r; c_w_r <= c0_w_r;
              dr_r <= dr_r + DCW'(1); r_raw_r <= r_raw_r + RW'(1); r_w_r <= r_inc;
            end else begin
              dc_r <= dc_r + DCW'(1); c_raw_r <= c_raw_r + RW'(1); c_w_r <= c_inc;
            end
          end else begin
            state_r <= S_FRD;
          end
        end
        S_FRD: state_r <= S_FWAIT;
        S_FWAIT: begin
          fill_r  <= f_rdata;
          k_r     <= '0;
          state_r <= (act_r == gnq_pkg::ACT_INSERT) ? S_INS : S_ERD;
        end
        S_ERD: begin
          if (k_r < fill_r) state_r <= S_EWAIT;
          else if (walk_done) state_r <= S_FIN;
          else begin
            state_r <= S_CELL;
            if (last_col) begin
              dc_r <= '0; c_raw_r <= c0_raw_r; c_w_r <= c0_w_r;
              dr_r <= dr_r + DCW'(1); r_raw_r <= r_raw_r + RW'(1); r_w_r <= r_inc;
            end else begin
              dc_r <= dc_r + DCW'(1); c_raw_r <= c_raw_r + RW'(1); c_w_r <= c_inc;
            end
          end
        end
        S_EWAIT: begin
          if (out_free) begin
            if (n_r == gnq_pkg::CNT_W'(gnq_pkg::OUT_CAP)) begin
              out_idx_r  <= pend_r;
              out_fv_r   <= 1'b1;
              out_last_r <= 1'b1;
              out_st_r   <= gnq_pkg::ST_TRUNC;
              state_r    <= S_IDLE;
            end else begin
              if (n_r != '0) begin
                out_idx_r  <= pend_r;
                out_fv_r   <= 1'b1;
                out_last_r <= 1'b0;
                out_st_r   <= gnq_pkg::ST_OK;
              end
              pend_r  <= e_rdata;
              n_r     <= n_r + gnq_pkg::CNT_W'(1);
              k_r     <= k_r + FW'(1);
              state_r <= S_ERD;
            end
          end
        end
        S_INS: begin
          if (out_free) begin
            out_idx_r  <= '0;
            out_fv_r   <= 1'b0;
            out_last_r <= 1'b1;
            out_st_r   <= drop ? gnq_pkg::ST_DROP : gnq_pkg::ST_OK;
            state_r    <= S_IDLE;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_idx_r  <= (n_r != '0) ? pend_r : '0;
            out_fv_r   <= (n_r != '0);
            out_last_r <= 1'b1;
            out_st_r   <= gnq_pkg::ST_OK;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/gnq_ram.sv
// gnq_ram: generic single-write, single-read ram with registered read data
// no dependencies
module gnq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hw/rtl/gnq_div.sv
// gnq_div: restoring divider, one quotient bit per cycle
// depends on gnq_pkg
module gnq_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [gnq_pkg::QUOT_W-1:0]         dividend,
  input  logic [gnq_pkg::EDGE_W-1:0]         divisor,
  output logic                               done,
  output logic [gnq_pkg::QUOT_W-1:0]         quotient
);
  localparam int QW = gnq_pkg::QUOT_W;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] quot_r;
  logic [QW-1:0] rem_r;
  logic [gnq_pkg::EDGE_W-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [QW-1:0] trial;
  logic          fits;

  assign trial = {rem_r[QW-2:0], quot_r[QW-1]};
  assign fits  = trial >= QW'(dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QW);
        quot_r <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= fits ? trial - QW'(dvs_r) : trial;
        quot_r <= {quot_r[QW-2:0], fits};
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;
endmodule

>>> verif/uniform_grid_neighbor_query_unit_test.sv
// testbench of uniform_grid_neighbor_query_unit: directed and random clear, insert and query
// requests checked against an in-bench grid predictor with random stalls on both channels
// depends on gnq_pkg, gnq_if and the unit itself
module uniform_grid_neighbor_query_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS = gnq_pkg::DEF_MAX_COLS;
  localparam int NROWS = gnq_pkg::DEF_MAX_ROWS;
  localparam int CAP   = gnq_pkg::DEF_BUCKET_CAP;
  localparam int SPAN  = gnq_pkg::DEF_MAX_SPAN;
  localparam int IW    = gnq_pkg::IDX_W;

  typedef struct {
    logic [IW-1:0]     found_index;
    logic              found_valid;
    logic              last;
    gnq_pkg::status_t  status;
  } hit_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [gnq_pkg::CFG_IX_W-1:0] cfg_index;
  logic [gnq_pkg::CFG_W-1:0] cfg_data;

  gnq_in_if  in_chan();
  gnq_out_if out_chan();

  uniform_grid_neighbor_query_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_chan(in_chan), .out_chan(out_chan)
  );

  int grid_fill [NCOLS*NROWS];
  logic [IW-1:0] grid_entries [NCOLS*NROWS*CAP];
  int cols_cfg, rows_cfg, edge_cfg, wrap_cfg;
  hit_t expected_hits[$];
  int failures = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int cols_eff();
    return cols_cfg < 1 ? 1 : (cols_cfg > NCOLS ? NCOLS : cols_cfg);
  endfunction

  function automatic int rows_eff();
    return rows_cfg < 1 ? 1 : (rows_cfg > NROWS ? NROWS : rows_cfg);
  endfunction

  function automatic int edge_eff();
    return edge_cfg == 0 ? 1 : edge_cfg;
  endfunction

  function automatic int bin_of(int p, int limit);
    int q;
    if (p < 0) return 0;
    q = p / edge_eff();
    return q > limit - 1 ? limit - 1 : q;
  endfunction

  function automatic void push_hit(int idx, bit fv, bit lst, gnq_pkg::status_t st);
    hit_t h;
    h.found_index = idx[IW-1:0];
    h.found_valid = fv;
    h.last = lst;
    h.status = st;
    expected_hits.insert(expected_hits.size(), h);
  endfunction

  function automatic void predict_grid(gnq_pkg::action_t act, int idx, int px, int py,
                                       int rad);
    int cols, rows, cell_ix, span, cc, cr, c, r, n;
    bit trunc;
    cols = cols_eff();
    rows = rows_eff();
    n = 0;
    trunc = 0;
    case (act)
      gnq_pkg::ACT_CLEAR: begin
        foreach (grid_fill[i]) grid_fill[i] = 0;
      end
      gnq_pkg::ACT_INSERT: begin
        cell_ix = bin_of(py, rows) * cols + bin_of(px, cols);
        if (grid_fill[cell_ix] >= CAP || idx >= gnq_pkg::DEF_MAX_ITEMS) begin
          push_hit(0, 0, 1, gnq_pkg::ST_DROP);
        end else begin
          grid_entries[cell_ix*CAP + grid_fill[cell_ix]] = idx[IW-1:0];
          grid_fill[cell_ix]++;
          push_hit(0, 0, 1, gnq_pkg::ST_OK);
        end
      end
      gnq_pkg::ACT_QUERY: begin
        span = (rad + edge_eff() - 1) / edge_eff();
        if (span > SPAN) span = SPAN;
        cc = bin_of(px, cols);
        cr = bin_of(py, rows);
        for (int dr = -span; dr <= span && !trunc; dr++) begin
          for (int dc = -span; dc <= span && !trunc; dc++) begin
            c = cc + dc;
            r = cr + dr;
            if (wrap_cfg != 0) begin
              c = ((c % cols) + cols) % cols;
              r = ((r % rows) + rows) % rows;
            end else if (c < 0 || c >= cols || r < 0 || r >= rows) begin
              continue;
            end
            cell_ix = r * cols + c;
            for (int k = 0; k < grid_fill[cell_ix]; k++) begin
              if (n >= gnq_pkg::OUT_CAP) begin
                trunc = 1;
                break;
              end
              push_hit(grid_entries[cell_ix*CAP + k], 1, 0, gnq_pkg::ST_OK);
              n++;
            end
          end
        end
        if (n == 0) begin
          push_hit(0, 0, 1, gnq_pkg::ST_OK);
        end else begin
          expected_hits[$].last = 1'b1;
          if (trunc) expected_hits[$].status = gnq_pkg::ST_TRUNC;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(gnq_pkg::action_t act, int idx, int px, int py, int rad);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(3, 1) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.action <= act;
    in_chan.item_index <= idx[IW-1:0];
    in_chan.pos_x <= px[gnq_pkg::POS_W-1:0];
    in_chan.pos_y <= py[gnq_pkg::POS_W-1:0];
    in_chan.search_radius <= rad[gnq_pkg::EDGE_W-1:0];
    do @(posedge clk); while (!in_chan.ready);
    predict_grid(act, idx & 32'h3ff, $signed(px[gnq_pkg::POS_W-1:0]),
                 $signed(py[gnq_pkg::POS_W-1:0]), rad & 32'h7fff);
  endtask

  task automatic drain_grid();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic write_reg(gnq_pkg::reg_ix_t ix, int value);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= value[gnq_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ix)
      gnq_pkg::REG_COLS: cols_cfg = value & 32'h3f;
      gnq_pkg::REG_ROWS: rows_cfg = value & 32'h3f;
      gnq_pkg::REG_EDGE: edge_cfg = value & 32'h7fff;
      default:           wrap_cfg = value & 1;
    endcase
  endtask

  task automatic set_grid(int cols, int rows, int edge_len, int wrap);
    drain_grid();
    write_reg(gnq_pkg::REG_COLS, cols);
    write_reg(gnq_pkg::REG_ROWS, rows);
    write_reg(gnq_pkg::REG_EDGE, edge_len);
    write_reg(gnq_pkg::REG_WRAP, wrap);
    send_request(gnq_pkg::ACT_CLEAR, 0, 0, 0, 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_hits.size() == 0) begin
        failures++;
        $display("%0t unexpected result: got index %0d valid %0b last %0b status %0d",
                 $time, out_chan.found_index, out_chan.found_valid, out_chan.last,
                 out_chan.status);
      end else begin
        hit_t e;
        e = expected_hits.pop_front();
        if (out_chan.found_index !== e.found_index || out_chan.found_valid !== e.found_valid
            || out_chan.last !== e.last || out_chan.status !== e.status) begin
          failures++;
          $display("%0t mismatch: expected index %0d valid %0b last %0b status %0d, got %0d %0b %0b %0d",
                   $time, e.found_index, e.found_valid, e.last, e.status,
                   out_chan.found_index, out_chan.found_valid, out_chan.last,
                   out_chan.status);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_directed();
    set_grid(32, 32, 256, 1);
    send_request(gnq_pkg::ACT_INSERT, 0, 0, 0, 0);
    send_request(gnq_pkg::ACT_INSERT, 1023, 32767, 32767, 0);
    send_request(gnq_pkg::ACT_INSERT, 5, -32768, -32768, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 0, 0, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 32767, -1, 32767);
    send_request(gnq_pkg::ACT_NONE, 7, 100, 100, 100);
    for (int i = 0; i < 9; i++) send_request(gnq_pkg::ACT_INSERT, 100 + i, 600, 600, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 600, 600, 1);
    send_request(gnq_pkg::ACT_QUERY, 0, 4000, 4000, 0);
    send_request(gnq_pkg::ACT_CLEAR, 0, 0, 0, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 600, 600, 32767);
  endtask

  task automatic test_small_torus();
    set_grid(2, 2, 16, 1);
    for (int i = 0; i < 4; i++) send_request(gnq_pkg::ACT_INSERT, 200 + i, 0, 0, 0);
    send_request(gnq_pkg::ACT_INSERT, 300, 20, 20, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 0, 0, 64);
    send_request(gnq_pkg::ACT_QUERY, 0, 20, 0, 17);
  endtask

  task automatic test_register_extremes();
    set_grid(1, 1, 1, 0);
    send_request(gnq_pkg::ACT_INSERT, 11, 32767, -5, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 3, 3, 32767);
    set_grid(63, 0, 0, 1);
    send_request(gnq_pkg::ACT_INSERT, 12, 31, 0, 0);
    send_request(gnq_pkg::ACT_INSERT, 13, 40, 2, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 0, 0, 2);
    set_grid(32, 32, 32767, 0);
    send_request(gnq_pkg::ACT_INSERT, 14, 32767, 32767, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 0, 0, 1);
    set_grid(5, 7, 100, 0);
    send_request(gnq_pkg::ACT_INSERT, 15, 0, 690, 0);
    send_request(gnq_pkg::ACT_QUERY, 0, 0, 690, 250);
  endtask

  task automatic random_traffic(int count);
    int roll, w, h, rad;
    w = cols_eff() * edge_eff();
    h = rows_eff() * edge_eff();
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      rad = $urandom_range(3 * edge_eff());
      if (roll < 2)
        send_request(gnq_pkg::ACT_CLEAR, 0, 0, 0, 0);
      else if (roll < 4)
        send_request(gnq_pkg::ACT_NONE, $urandom, $urandom, $urandom, $urandom);
      else if (roll < 12)
        send_request(gnq_pkg::action_t'($urandom_range(2, 1)), $urandom, $urandom,
                     $urandom, $urandom);
      else if (roll < 62)
        send_request(gnq_pkg::ACT_INSERT, $urandom_range(1023),
                     $urandom_range(w > 32767 ? 32767 : w),
                     $urandom_range(h > 32767 ? 32767 : h), $urandom);
      else
        send_request(gnq_pkg::ACT_QUERY, $urandom, $urandom_range(w > 32767 ? 32767 : w),
                     $urandom_range(h > 32767 ? 32767 : h), rad);
    end
  endtask

  task automatic test_random_phases();
    send_idle_pct = 17;
    recv_idle_pct = 75;
    set_grid($urandom_range(32, 4), $urandom_range(32, 4), $urandom_range(400, 16), 1);
    random_traffic(100);
    send_idle_pct = 75;
    recv_idle_pct = 17;
    set_grid($urandom_range(12, 1), $urandom_range(12, 1), $urandom_range(3000, 16), 0);
    random_traffic(100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid($urandom_range(32, 1), $urandom_range(32, 1), $urandom_range(200, 8),
             $urandom_range(1));
    random_traffic(100);
  endtask

  task automatic test_output_hold();
    set_grid(4, 4, 64, 1);
    hold_left = 600;
    for (int i = 0; i < 16; i++)
      send_request(gnq_pkg::action_t'(i % 2 ? gnq_pkg::ACT_QUERY : gnq_pkg::ACT_INSERT),
                   i, 20 * i, 10 * i, 64);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_chan.valid = 1'b0;
    in_chan.action = gnq_pkg::ACT_CLEAR;
    in_chan.item_index = '0;
    in_chan.pos_x = '0;
    in_chan.pos_y = '0;
    in_chan.search_radius = '0;
    out_chan.ready = 1'b0;
    foreach (grid_fill[i]) grid_fill[i] = 0;
    cols_cfg = gnq_pkg::RST_COLS;
    rows_cfg = gnq_pkg::RST_ROWS;
    edge_cfg = gnq_pkg::RST_EDGE;
    wrap_cfg = gnq_pkg::RST_WRAP;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_small_torus();
    test_register_extremes();
    test_output_hold();
    test_random_phases();
    drain_grid();
    if (failures == 0 && expected_hits.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
